// ----- hw/rtl/i2c_ras_pkg.sv -----
// types and codes shared by the i2c register access sequencer
package i2c_ras_pkg;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] reg_index;
		logic [7:0] write_value;
		logic [7:0] read_length;
		logic [7:0] bus_status;
		logic [7:0] bus_data;
	} req_item_t;

	typedef struct packed {
		logic [2:0] bus_action;
		logic [7:0] send_byte;
		logic       read_valid;
		logic [7:0] read_byte;
		logic       done_res;
		logic       failed;
	} rsp_item_t;

	// request opcodes
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_EVENT = 2'd2;

	// bus actions
	localparam logic [2:0] ACT_NONE  = 3'd0;
	localparam logic [2:0] ACT_START = 3'd1;
	localparam logic [2:0] ACT_SEND  = 3'd2;
	localparam logic [2:0] ACT_RACK  = 3'd3;
	localparam logic [2:0] ACT_RNACK = 3'd4;
	localparam logic [2:0] ACT_STOP  = 3'd5;

	// bus controller status codes
	localparam logic [7:0] ST_START    = 8'h08;
	localparam logic [7:0] ST_RESTART  = 8'h10;
	localparam logic [7:0] ST_ADDRW_OK = 8'h18;
	localparam logic [7:0] ST_DATA_OK  = 8'h28;
	localparam logic [7:0] ST_ADDRR_OK = 8'h40;

	localparam logic [6:0] DEV_ADDR_RESET = 7'h68;

	// apb register map
	localparam int          PADDR_W    = 3;
	localparam logic        REG_DEVICE = 1'b0;

endpackage

// ----- hw/rtl/i2c_ras_cfg.sv -----
// apb configuration register: device address
module i2c_ras_cfg
	import i2c_ras_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output logic [6:0]         dev_addr
);

	logic [6:0] dev_addr_q;
	logic       wr_en;
	logic       sel_dev;

	assign pready  = 1'b1;
	// word index is the upper address bit, byte offset ignored
	assign sel_dev = (paddr[PADDR_W-1] == REG_DEVICE);
	assign wr_en   = psel & penable & pwrite & pready & sel_dev;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= DEV_ADDR_RESET;
		end else if (wr_en) begin
			dev_addr_q <= pwdata[6:0];
		end
	end

	assign prdata   = sel_dev ? {25'd0, dev_addr_q} : 32'd0;
	assign dev_addr = dev_addr_q;

endmodule

// ----- hw/rtl/i2c_ras_seq.sv -----
// transaction state and next bus action for one item
module i2c_ras_seq
	import i2c_ras_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  req_item_t item,
	input  logic [6:0] dev_addr,
	output rsp_item_t rsp
);

	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_START1  = 3'd1;
	localparam logic [2:0] PH_ADDRW   = 3'd2;
	localparam logic [2:0] PH_REG     = 3'd3;
	localparam logic [2:0] PH_VALUE   = 3'd4;
	localparam logic [2:0] PH_RESTART = 3'd5;
	localparam logic [2:0] PH_ADDRR   = 3'd6;
	localparam logic [2:0] PH_READ    = 3'd7;

	logic [2:0] phase_q, phase_d;
	logic       is_read_q, is_read_d;
	logic [7:0] saved_reg_q, saved_reg_d;
	logic [7:0] saved_val_q, saved_val_d;
	logic [7:0] bytes_left_q, bytes_left_d;

	logic       start_ok;
	logic       send_ok;
	logic [7:0] addr_w;
	logic [7:0] left_dec;

	assign start_ok = (item.bus_status == ST_START) || (item.bus_status == ST_RESTART);
	assign send_ok  = (item.bus_status == ST_ADDRW_OK) || (item.bus_status == ST_DATA_OK)
		|| (item.bus_status == ST_ADDRR_OK);
	assign addr_w   = {dev_addr, 1'b0};
	assign left_dec = (bytes_left_q != 8'd0) ? bytes_left_q - 8'd1 : 8'd0;

	always_comb begin
		rsp          = '0;
		phase_d      = phase_q;
		is_read_d    = is_read_q;
		saved_reg_d  = saved_reg_q;
		saved_val_d  = saved_val_q;
		bytes_left_d = bytes_left_q;
		// unused opcode falls through both branches and leaves everything as is
		if (item.opcode == OP_WRITE || item.opcode == OP_READ) begin
			if (phase_q == PH_IDLE) begin
				is_read_d      = (item.opcode == OP_READ);
				saved_reg_d    = item.reg_index;
				saved_val_d    = item.write_value;
				bytes_left_d   = item.read_length;
				phase_d        = PH_START1;
				rsp.bus_action = ACT_START;
			end
		end else if (item.opcode == OP_EVENT) begin
			unique case (phase_q)
				PH_IDLE: begin
				end
				PH_START1: begin
					if (start_ok) begin
						rsp.bus_action = ACT_SEND;
						rsp.send_byte  = addr_w;
						phase_d        = PH_ADDRW;
					end else begin
						// failed first start ends without a stop
						rsp.done_res = 1'b1;
						rsp.failed   = 1'b1;
						phase_d      = PH_IDLE;
					end
				end
				PH_ADDRW: begin
					if (send_ok) begin
						rsp.bus_action = ACT_SEND;
						rsp.send_byte  = saved_reg_q;
						phase_d        = PH_REG;
					end else begin
						rsp.bus_action = ACT_STOP;
						rsp.done_res   = 1'b1;
						rsp.failed     = 1'b1;
						phase_d        = PH_IDLE;
					end
				end
				PH_REG: begin
					if (!send_ok) begin
						rsp.bus_action = ACT_STOP;
						rsp.done_res   = 1'b1;
						rsp.failed     = 1'b1;
						phase_d        = PH_IDLE;
					end else if (is_read_q) begin
						rsp.bus_action = ACT_START;
						phase_d        = PH_RESTART;
					end else begin
						rsp.bus_action = ACT_SEND;
						rsp.send_byte  = saved_val_q;
						phase_d        = PH_VALUE;
					end
				end
				PH_VALUE: begin
					rsp.bus_action = ACT_STOP;
					rsp.done_res   = 1'b1;
					rsp.failed     = !send_ok;
					phase_d        = PH_IDLE;
				end
				PH_RESTART: begin
					if (start_ok) begin
						rsp.bus_action = ACT_SEND;
						rsp.send_byte  = {dev_addr, 1'b1};
						phase_d        = PH_ADDRR;
					end else begin
						rsp.bus_action = ACT_STOP;
						rsp.done_res   = 1'b1;
						rsp.failed     = 1'b1;
						phase_d        = PH_IDLE;
					end
				end
				PH_ADDRR: begin
					if (!send_ok || bytes_left_q == 8'd0) begin
						rsp.bus_action = ACT_STOP;
						rsp.done_res   = 1'b1;
						rsp.failed     = !send_ok;
						phase_d        = PH_IDLE;
					end else begin
						rsp.bus_action = (bytes_left_q > 8'd1) ? ACT_RACK : ACT_RNACK;
						phase_d        = PH_READ;
					end
				end
				PH_READ: begin
					rsp.read_valid = 1'b1;
					rsp.read_byte  = item.bus_data;
					bytes_left_d   = left_dec;
					if (left_dec == 8'd0) begin
						rsp.bus_action = ACT_STOP;
						rsp.done_res   = 1'b1;
						phase_d        = PH_IDLE;
					end else begin
						rsp.bus_action = (left_dec > 8'd1) ? ACT_RACK : ACT_RNACK;
						phase_d        = PH_READ;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			is_read_q    <= 1'b0;
			saved_reg_q  <= 8'd0;
			saved_val_q  <= 8'd0;
			bytes_left_q <= 8'd0;
		end else if (step) begin
			phase_q      <= phase_d;
			is_read_q    <= is_read_d;
			saved_reg_q  <= saved_reg_d;
			saved_val_q  <= saved_val_d;
			bytes_left_q <= bytes_left_d;
		end
	end

endmodule

// ----- hw/rtl/i2c_register_access_sequencer.sv -----
// i2c register access sequencer: top level
//
// req channel (valid/ready) carries write requests, read requests and bus
// completion events; rsp channel (valid/ready) returns one item per request
// or event: the next bus action, the byte to send, a received byte, and
// done/failed flags when a transaction ends. Items that do not apply (request
// while busy, event while idle, unused opcode) return an all-zero item.
// An accepted item is held in an input register; when the output register is
// free or drains, the sequencer logic turns it into a result in the output
// register and updates its state.
// Throughput: one item per cycle while rsp_ready keeps the output draining.
// If rsp_ready is low, the output register holds its item and one more item
// waits in the input register; req_ready drops only when both are full.
// Reset clears both pipeline valids and the transaction state to idle and
// sets the device address to 0x68. The apb port writes the device address
// at byte address 0; it is meant to be written while the block is idle.
module i2c_register_access_sequencer
	import i2c_ras_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  req_item_t          req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output rsp_item_t          rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic       valid_s1;
	req_item_t  item_s1;
	logic       valid_s2;
	rsp_item_t  item_s2;
	rsp_item_t  rsp_d;
	logic       advance;
	logic [6:0] dev_addr;

	// s1 moves into the output register when that register is free or drains
	assign advance   = valid_s1 && (!valid_s2 || rsp_ready);
	assign req_ready = !valid_s1 || advance;

	i2c_ras_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.dev_addr (dev_addr)
	);

	i2c_ras_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.item     (item_s1),
		.dev_addr (dev_addr),
		.rsp      (rsp_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_s2 <= rsp_d;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp       = item_s2;

	a_fail_ends : assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.failed |-> rsp.done_res)
		else $error("failed result without done");

	a_read_action : assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.read_valid |->
			(rsp.bus_action == ACT_RACK || rsp.bus_action == ACT_RNACK
			|| rsp.bus_action == ACT_STOP))
		else $error("received byte with wrong bus action");

	a_ready_stall : assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> (valid_s1 && valid_s2 && !rsp_ready))
		else $error("req_ready low without a full stall");

	a_advance_out : assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp_valid)
		else $error("processed item did not reach the output");

endmodule

// ----- tb/sv/i2c_register_access_sequencer_tb.sv -----
// testbench for the i2c register access sequencer: directed flows, backpressure and random traffic
`timescale 1ns / 100ps

module i2c_register_access_sequencer_tb;
	import i2c_ras_pkg::*;

	typedef enum logic [2:0] {
		XF_IDLE, XF_START, XF_ADDR_W, XF_REG, XF_VALUE, XF_RESTART, XF_ADDR_R, XF_READ
	} xfer_phase_t;

	localparam logic [1:0]         OP_UNUSED    = 2'd3;
	localparam logic [PADDR_W-1:0] DEV_REG_ADDR = {REG_DEVICE, 2'b00};

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_ready;
	req_item_t          req       = '0;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	rsp_item_t          rsp;
	logic               psel      = 1'b0;
	logic               penable   = 1'b0;
	logic               pwrite    = 1'b0;
	logic [PADDR_W-1:0] paddr     = '0;
	logic [31:0]        pwdata    = '0;
	logic [31:0]        prdata;
	logic               pready;

	// sequencer state as predicted
	logic [6:0]  dev_addr = DEV_ADDR_RESET;
	xfer_phase_t xfer_phase = XF_IDLE;
	logic        xfer_is_read = 1'b0;
	logic [7:0]  xfer_reg = '0;
	logic [7:0]  xfer_value = '0;
	logic [7:0]  xfer_left = '0;

	rsp_item_t bus_steps_due[$];
	int        errors = 0;
	int        items_handled = 0;
	bit        send_idle_on = 1'b0;
	bit        ready_idle_on = 1'b0;
	int        long_hold = 0;
	int        stall_left = 0;

	i2c_register_access_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic bit start_ok(input logic [7:0] s);
		return s == ST_START || s == ST_RESTART;
	endfunction

	function automatic bit send_ok(input logic [7:0] s);
		return s == ST_ADDRW_OK || s == ST_DATA_OK || s == ST_ADDRR_OK;
	endfunction

	function automatic rsp_item_t end_xfer(input rsp_item_t r, input logic [2:0] act,
			input logic fail);
		r.bus_action = act;
		r.done_res = 1'b1;
		r.failed = fail;
		xfer_phase = XF_IDLE;
		return r;
	endfunction

	// next bus action for one accepted item, advancing the predicted state
	function automatic rsp_item_t next_bus_step(input req_item_t it);
		rsp_item_t  r;
		logic [7:0] addr_byte;
		r = '0;
		addr_byte = {dev_addr, 1'b0};
		if (it.opcode == OP_WRITE || it.opcode == OP_READ) begin
			if (xfer_phase == XF_IDLE) begin
				xfer_is_read = (it.opcode == OP_READ);
				xfer_reg = it.reg_index;
				xfer_value = it.write_value;
				xfer_left = it.read_length;
				xfer_phase = XF_START;
				r.bus_action = ACT_START;
			end
			return r;
		end
		if (it.opcode != OP_EVENT)
			return r;
		case (xfer_phase)
			XF_START: begin
				if (start_ok(it.bus_status)) begin
					r.bus_action = ACT_SEND;
					r.send_byte = addr_byte;
					xfer_phase = XF_ADDR_W;
				end else begin
					// failed first start: no stop goes out
					r = end_xfer(r, ACT_NONE, 1'b1);
				end
			end
			XF_ADDR_W: begin
				if (send_ok(it.bus_status)) begin
					r.bus_action = ACT_SEND;
					r.send_byte = xfer_reg;
					xfer_phase = XF_REG;
				end else begin
					r = end_xfer(r, ACT_STOP, 1'b1);
				end
			end
			XF_REG: begin
				if (!send_ok(it.bus_status)) begin
					r = end_xfer(r, ACT_STOP, 1'b1);
				end else if (xfer_is_read) begin
					r.bus_action = ACT_START;
					xfer_phase = XF_RESTART;
				end else begin
					r.bus_action = ACT_SEND;
					r.send_byte = xfer_value;
					xfer_phase = XF_VALUE;
				end
			end
			XF_VALUE: begin
				r = end_xfer(r, ACT_STOP, !send_ok(it.bus_status));
			end
			XF_RESTART: begin
				if (start_ok(it.bus_status)) begin
					r.bus_action = ACT_SEND;
					r.send_byte = addr_byte | 8'h01;
					xfer_phase = XF_ADDR_R;
				end else begin
					r = end_xfer(r, ACT_STOP, 1'b1);
				end
			end
			XF_ADDR_R: begin
				if (!send_ok(it.bus_status)) begin
					r = end_xfer(r, ACT_STOP, 1'b1);
				end else if (xfer_left == 8'd0) begin
					r = end_xfer(r, ACT_STOP, 1'b0);
				end else begin
					r.bus_action = (xfer_left > 8'd1) ? ACT_RACK : ACT_RNACK;
					xfer_phase = XF_READ;
				end
			end
			XF_READ: begin
				// read status is never checked
				r.read_valid = 1'b1;
				r.read_byte = it.bus_data;
				if (xfer_left > 8'd0)
					xfer_left = xfer_left - 8'd1;
				if (xfer_left == 8'd0) begin
					r = end_xfer(r, ACT_STOP, 1'b0);
				end else begin
					r.bus_action = (xfer_left > 8'd1) ? ACT_RACK : ACT_RNACK;
					xfer_phase = XF_READ;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic logic [7:0] good_status();
		case (xfer_phase)
			XF_START, XF_RESTART: return $urandom_range(0, 1) ? ST_START : ST_RESTART;
			XF_READ: return 8'($urandom);
			default: begin
				case ($urandom_range(0, 2))
					0: return ST_ADDRW_OK;
					1: return ST_DATA_OK;
					default: return ST_ADDRR_OK;
				endcase
			end
		endcase
	endfunction

	function automatic logic [7:0] bad_status();
		logic [7:0] s;
		do
			s = 8'($urandom);
		while (start_ok(s) || send_ok(s));
		return s;
	endfunction

	task automatic send_item(input req_item_t it);
		rsp_item_t want;
		int        gap;
		req <= it;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (!req_ready);
		want = next_bus_step(it);
		bus_steps_due.push_back(want);
		if (want != '0)
			items_handled++;
		gap = send_idle_on ? gap_len() : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_request(input logic [1:0] op, input logic [7:0] rix,
			input logic [7:0] val, input logic [7:0] len);
		req_item_t it;
		it = req_item_t'({$urandom, $urandom});
		it.opcode = op;
		it.reg_index = rix;
		it.write_value = val;
		it.read_length = len;
		send_item(it);
	endtask

	task automatic send_event(input logic [7:0] status);
		req_item_t it;
		it = req_item_t'({$urandom, $urandom});
		it.opcode = OP_EVENT;
		it.bus_status = status;
		send_item(it);
	endtask

	task automatic send_unused();
		req_item_t it;
		it = req_item_t'({$urandom, $urandom});
		it.opcode = OP_UNUSED;
		send_item(it);
	endtask

	// one request and the bus events that carry it to its end
	task automatic run_transaction(input logic [1:0] op, input logic [7:0] rix,
			input logic [7:0] val, input logic [7:0] len, input int bad_step,
			input int fail_pct, input int noise_pct);
		int         n;
		logic [7:0] st;
		send_request(op, rix, val, len);
		n = 0;
		while (xfer_phase != XF_IDLE) begin
			if ($urandom_range(0, 99) < noise_pct) begin
				if ($urandom_range(0, 1))
					send_request($urandom_range(0, 1) ? OP_READ : OP_WRITE, 8'($urandom),
						8'($urandom), 8'($urandom));
				else
					send_unused();
			end
			if (n == bad_step || $urandom_range(0, 99) < fail_pct)
				st = bad_status();
			else
				st = good_status();
			send_event(st);
			n++;
		end
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (bus_steps_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// psel stays high between back-to-back accesses; callers drop it
	task automatic apb_access(input bit wr, input logic [31:0] data, output logic [31:0] rd);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= DEV_REG_ADDR;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		rd = prdata;
	endtask

	task automatic read_back_device();
		logic [31:0] rd;
		apb_access(1'b0, '0, rd);
		if (rd[6:0] !== dev_addr) begin
			$display("%0t: device_address expected %0h, got %0h", $time, dev_addr, rd[6:0]);
			errors++;
		end
	endtask

	task automatic set_device_address(input logic [6:0] a);
		logic [31:0] rd;
		drain();
		apb_access(1'b1, {25'b0, a}, rd);
		dev_addr = a;
		read_back_device();
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : check_rsp
		rsp_item_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (bus_steps_due.size() == 0) begin
				$display("%0t: unexpected item, expected none, got %h", $time, rsp);
				errors++;
			end else begin
				want = bus_steps_due.pop_front();
				check_field("bus_action", 8'(want.bus_action), 8'(rsp.bus_action));
				check_field("send_byte", want.send_byte, rsp.send_byte);
				check_field("read_valid", 8'(want.read_valid), 8'(rsp.read_valid));
				check_field("read_byte", want.read_byte, rsp.read_byte);
				check_field("done_res", 8'(want.done_res), 8'(rsp.done_res));
				check_field("failed", 8'(want.failed), 8'(rsp.failed));
			end
		end
	end

	// receiver: random stalls, or one long hold when asked
	always @(posedge clk) begin
		if (long_hold > 0) begin
			stall_left = long_hold;
			long_hold = 0;
		end else if (stall_left == 0 && ready_idle_on) begin
			stall_left = gap_len();
		end
		rsp_ready <= (stall_left == 0);
		if (stall_left > 0)
			stall_left--;
	end

	task automatic test_config_register();
		read_back_device();
		psel <= 1'b0;
		penable <= 1'b0;
		set_device_address(7'h00);
		set_device_address(7'h7F);
		set_device_address(DEV_ADDR_RESET);
	endtask

	task automatic test_write_path();
		send_idle_on = 1'b1;
		ready_idle_on = 1'b1;
		run_transaction(OP_WRITE, 8'hFF, 8'h00, 8'h00, -1, 0, 0);
	endtask

	task automatic test_read_path();
		// zero-length read stops right after the read address
		run_transaction(OP_READ, 8'h00, 8'hFF, 8'd0, -1, 0, 0);
		run_transaction(OP_READ, 8'h80, 8'hFF, 8'd1, -1, 0, 0);
	endtask

	task automatic test_ignored_items();
		send_event(8'($urandom));
		send_unused();
		// first start fails, with a request or an unused item sneaking in while busy
		run_transaction(OP_WRITE, 8'h5A, 8'hA5, 8'hFF, 0, 0, 100);
	endtask

	task automatic test_backpressure();
		send_idle_on = 1'b0;
		ready_idle_on = 1'b0;
		long_hold = 60;
		run_transaction(OP_READ, 8'h3C, 8'h00, 8'd6, -1, 0, 0);
		run_transaction(OP_WRITE, 8'hC3, 8'h7E, 8'd0, -1, 0, 0);
		drain();
		long_hold = 40;
		run_transaction(OP_READ, 8'h11, 8'h22, 8'd3, -1, 0, 0);
		drain();
	endtask

	task automatic random_phase(input logic [6:0] a, input bit idling, input int quota);
		int         target;
		logic [1:0] op;
		logic [7:0] len;
		set_device_address(a);
		send_idle_on = idling;
		ready_idle_on = idling;
		target = items_handled + quota;
		while (items_handled < target) begin
			case ($urandom_range(0, 19))
				0: send_event(8'($urandom));
				1: send_unused();
				default: begin
					op = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
					if ($urandom_range(0, 49) == 0)
						len = 8'($urandom_range(32, 255));
					else
						len = 8'($urandom_range(0, 5));
					run_transaction(op, 8'($urandom), 8'($urandom), len, -1, 6, 5);
				end
			endcase
		end
	endtask

	task automatic test_random_traffic();
		random_phase(7'($urandom), 1'b0, 110);
		random_phase(7'h00, 1'b1, 110);
		random_phase(7'h7F, 1'b1, 110);
		random_phase(DEV_ADDR_RESET, 1'b1, 110);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_config_register();
		test_write_path();
		test_read_path();
		test_ignored_items();
		test_backpressure();
		test_random_traffic();
		drain();
		if (errors == 0)
			$display("i2c_register_access_sequencer verification clean");
		else
			$display("i2c_register_access_sequencer verification failed");
		$finish;
	end

	initial begin
		#(20_000_000);
		$display("i2c_register_access_sequencer verification failed");
		$finish;
	end

endmodule
